[sv/bced_pkg.sv]
// Shared types and constants for the button click event detector.
package bced_pkg;

  // Register file geometry
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned EventW   = 3;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEBOUNCE_ENABLE = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE_MS     = 2'd1;
  localparam logic [1:0] REG_LONG_PRESS_MS   = 2'd2;
  localparam logic [1:0] REG_DOUBLE_CLICK_MS = 2'd3;

  // Reset values
  localparam logic              RST_DEBOUNCE_ENABLE = 1'b1;
  localparam logic [LimitW-1:0] RST_DEBOUNCE_MS     = 16'd20;
  localparam logic [LimitW-1:0] RST_LONG_PRESS_MS   = 16'd1000;
  localparam logic [LimitW-1:0] RST_DOUBLE_CLICK_MS = 16'd300;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE     = 3'd0;
  localparam logic [EventW-1:0] EV_SINGLE   = 3'd1;
  localparam logic [EventW-1:0] EV_DOUBLE   = 3'd2;
  localparam logic [EventW-1:0] EV_LONG     = 3'd3;
  localparam logic [EventW-1:0] EV_LONG_REL = 3'd4;

  // Configuration bundle handed from the register file to the key FSM
  typedef struct packed {
    logic              debounce_enable;
    logic [LimitW-1:0] debounce_ms;
    logic [LimitW-1:0] long_press_ms;
    logic [LimitW-1:0] double_click_ms;
  } cfg_t;

endpackage

[sv/bced_cfg_regs.sv]
// APB-style configuration registers of the button click event detector.
module bced_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bced_pkg::CfgAddrW-1:0] paddr,
  input  logic [bced_pkg::CfgDataW-1:0] pwdata,
  output logic [bced_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output bced_pkg::cfg_t                cfg
);
  import bced_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_enable <= RST_DEBOUNCE_ENABLE;
      cfg_r.debounce_ms     <= RST_DEBOUNCE_MS;
      cfg_r.long_press_ms   <= RST_LONG_PRESS_MS;
      cfg_r.double_click_ms <= RST_DOUBLE_CLICK_MS;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DEBOUNCE_ENABLE: cfg_r.debounce_enable <= pwdata[0];
        REG_DEBOUNCE_MS:     cfg_r.debounce_ms     <= pwdata[LimitW-1:0];
        REG_LONG_PRESS_MS:   cfg_r.long_press_ms   <= pwdata[LimitW-1:0];
        REG_DOUBLE_CLICK_MS: cfg_r.double_click_ms <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_DEBOUNCE_ENABLE: prdata = {{(CfgDataW-1){1'b0}}, cfg_r.debounce_enable};
      REG_DEBOUNCE_MS:     prdata = {{(CfgDataW-LimitW){1'b0}}, cfg_r.debounce_ms};
      REG_LONG_PRESS_MS:   prdata = {{(CfgDataW-LimitW){1'b0}}, cfg_r.long_press_ms};
      REG_DOUBLE_CLICK_MS: prdata = {{(CfgDataW-LimitW){1'b0}}, cfg_r.double_click_ms};
      default:             prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[sv/bced_fsm.sv]
// Key state machine: one sample per step, one event code per step.
module bced_fsm (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        pressed,
  input  logic [bced_pkg::TimeW-1:0]  now_ms,
  input  bced_pkg::cfg_t              cfg,
  output logic [bced_pkg::EventW-1:0] event_code
);
  import bced_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DB_PRESS = 3'd1,
    ST_PRESS    = 3'd2,
    ST_DB_REL   = 3'd3,
    ST_WAIT_DBL = 3'd4,
    ST_WAIT_REL = 3'd5,
    ST_DB_FIN   = 3'd6
  } key_state_t;

  key_state_t        key_state_r, key_state_nxt;
  logic [TimeW-1:0]  stamp_ms_r, stamp_ms_nxt;
  logic              long_active_r, long_active_nxt;
  logic [LimitW-1:0] limit;
  logic [TimeW-1:0]  elapsed;
  logic              held;
  logic              db;

  assign db = cfg.debounce_enable;

  // Only one threshold matters per state: pick it, then one subtract and compare
  always_comb begin
    case (key_state_r)
      ST_DB_PRESS, ST_DB_REL, ST_DB_FIN: limit = cfg.debounce_ms;
      ST_PRESS:                          limit = cfg.long_press_ms;
      ST_WAIT_DBL:                       limit = cfg.double_click_ms;
      default:                           limit = '0;
    endcase
  end

  assign elapsed = now_ms - stamp_ms_r;   // wraps modulo 2^32
  assign held    = elapsed >= {{(TimeW-LimitW){1'b0}}, limit};

  // Next state and event
  always_comb begin
    key_state_nxt   = key_state_r;
    stamp_ms_nxt    = stamp_ms_r;
    long_active_nxt = long_active_r;
    event_code      = EV_NONE;
    case (key_state_r)
      ST_IDLE: begin
        if (pressed) begin
          stamp_ms_nxt    = now_ms;
          long_active_nxt = 1'b0;
          key_state_nxt   = db ? ST_DB_PRESS : ST_PRESS;
        end
      end
      ST_DB_PRESS: begin
        if (!db || !pressed) begin
          key_state_nxt = ST_IDLE;
        end else if (held) begin
          key_state_nxt = ST_PRESS;
          stamp_ms_nxt  = now_ms;
        end
      end
      ST_PRESS: begin
        if (pressed) begin
          if (held) begin
            event_code      = EV_LONG;
            long_active_nxt = 1'b1;
            key_state_nxt   = ST_WAIT_REL;
          end
        end else begin
          stamp_ms_nxt  = now_ms;
          key_state_nxt = db ? ST_DB_REL : ST_WAIT_DBL;
        end
      end
      ST_DB_REL: begin
        if (!db) begin
          key_state_nxt = ST_IDLE;
        end else if (pressed) begin
          key_state_nxt = ST_PRESS;
          stamp_ms_nxt  = now_ms;
        end else if (held) begin
          key_state_nxt = ST_WAIT_DBL;
          stamp_ms_nxt  = now_ms;
        end
      end
      ST_WAIT_DBL: begin
        if (pressed) begin
          event_code      = EV_DOUBLE;
          long_active_nxt = 1'b0;
          key_state_nxt   = ST_WAIT_REL;
        end else if (held) begin
          event_code    = EV_SINGLE;
          key_state_nxt = ST_IDLE;
        end
      end
      ST_WAIT_REL: begin
        if (!pressed) begin
          stamp_ms_nxt = now_ms;
          if (db) begin
            key_state_nxt = ST_DB_FIN;
          end else begin
            if (long_active_r) begin
              event_code      = EV_LONG_REL;
              long_active_nxt = 1'b0;
            end
            key_state_nxt = ST_IDLE;
          end
        end
      end
      ST_DB_FIN: begin
        if (!db) begin
          key_state_nxt = ST_IDLE;
        end else if (pressed) begin
          key_state_nxt = ST_WAIT_REL;
        end else if (held) begin
          if (long_active_r) begin
            event_code      = EV_LONG_REL;
            long_active_nxt = 1'b0;
          end
          key_state_nxt = ST_IDLE;
        end
      end
      default: key_state_nxt = ST_IDLE;
    endcase
  end

  // State registers, updated once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_state_r   <= ST_IDLE;
      stamp_ms_r    <= '0;
      long_active_r <= 1'b0;
    end else if (step) begin
      key_state_r   <= key_state_nxt;
      stamp_ms_r    <= stamp_ms_nxt;
      long_active_r <= long_active_nxt;
    end
  end

endmodule

[sv/button_click_event_detector.sv]
// Top level of the button click event detector: input register, key FSM, result register.
//
//   channel  | ports                                    | moves
//   ---------+------------------------------------------+-------------------------------
//   input    | in_valid, in_stall, in_pressed, in_now_ms | one key sample per beat
//   result   | out_valid, out_stall, out_event_res       | one event code per sample
//   config   | psel, penable, pwrite, paddr, pwdata,    | register writes and reads
//            | prdata, pready                           |
//
// One sample per cycle sustained while the result side is not stalled.
// The sample sits in the input register, the FSM step is combinational (one 32-bit
// subtract and compare) and the event lands in the result register.
// rst_n is synchronous; it empties both registers and returns the FSM to idle.
// A stalled result holds the FSM step; the input register then fills and in_stall rises.
module button_click_event_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pressed,
  input  logic [bced_pkg::TimeW-1:0]    in_now_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bced_pkg::EventW-1:0]   out_event_res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bced_pkg::CfgAddrW-1:0] paddr,
  input  logic [bced_pkg::CfgDataW-1:0] pwdata,
  output logic [bced_pkg::CfgDataW-1:0] prdata,
  output logic                          pready
);
  import bced_pkg::*;

  cfg_t              cfg;
  logic              s0_valid_r;
  logic              s0_pressed_r;
  logic [TimeW-1:0]  s0_now_r;
  logic              out_valid_r;
  logic [EventW-1:0] out_event_r;
  logic              out_block;
  logic              in_take;
  logic              step;
  logic [EventW-1:0] step_event;

  bced_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: the FSM steps whenever the input register holds a sample and the result register can take a beat
  assign out_block = out_valid_r && out_stall;
  assign step      = s0_valid_r && !out_block;
  assign in_stall  = s0_valid_r && out_block;
  assign in_take   = in_valid && !in_stall;

  bced_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .pressed    (s0_pressed_r),
    .now_ms     (s0_now_r),
    .cfg        (cfg),
    .event_code (step_event)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_take) begin
      s0_valid_r <= 1'b1;
    end else if (step) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_pressed_r <= in_pressed;
      s0_now_r     <= in_now_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event_r <= step_event;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_event_r;

endmodule

[sv/bced_checker.sv]
// Port-level assertions for the button click event detector, bound to the top level.
module bced_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bced_pkg::EventW-1:0]   out_event_res
);
  import bced_pkg::*;

  // A held result beat keeps its event code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res))
    else $error("result beat changed while stalled");

  // Only the five defined event codes leave the block
  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_res == EV_NONE || out_event_res == EV_SINGLE ||
                   out_event_res == EV_DOUBLE || out_event_res == EV_LONG ||
                   out_event_res == EV_LONG_REL))
    else $error("undefined event code");

  // The input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind button_click_event_detector bced_checker u_bced_checker (.*);

[verif/button_click_event_detector_tb.sv]
// Self-checking testbench for the button click event detector: key gestures in, event codes checked.
module button_click_event_detector_tb;
  import bced_pkg::*;

  localparam int unsigned N_ITEMS     = 1850;
  localparam int unsigned PHASE_ITEMS = 150;
  localparam int unsigned QUIET_LIMIT = 3000;

  // Key FSM state codes
  localparam logic [2:0] K_IDLE     = 3'd0;
  localparam logic [2:0] K_DB_PRESS = 3'd1;
  localparam logic [2:0] K_PRESS    = 3'd2;
  localparam logic [2:0] K_DB_REL   = 3'd3;
  localparam logic [2:0] K_WAIT_DBL = 3'd4;
  localparam logic [2:0] K_WAIT_REL = 3'd5;
  localparam logic [2:0] K_DB_FIN   = 3'd6;

  typedef struct {
    logic [EventW-1:0] event_res;
    int unsigned       seq;
  } click_exp_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_pressed;
  logic [TimeW-1:0]    in_now_ms;
  logic                out_valid;
  logic                out_stall;
  logic [EventW-1:0]   out_event_res;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Shadow of the register file and of the key FSM
  cfg_t             timing;
  logic [2:0]       key_st;
  logic [TimeW-1:0] press_stamp;
  logic             long_held;

  click_exp_t  pending_events[$];
  click_exp_t  oldest;
  int unsigned n_sent;
  int unsigned n_errors;
  int unsigned quiet_cycles;
  int unsigned stall_stretch;
  bit          send_gaps_on;
  bit          stall_gaps_on;
  logic [TimeW-1:0] tnow;
  int unsigned step_max;

  button_click_event_detector dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pressed    (in_pressed),
    .in_now_ms     (in_now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_res (out_event_res),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  // Advance the shadow FSM by one sample and return the event it gives
  function automatic logic [EventW-1:0] next_click_event(input logic lvl,
                                                         input logic [TimeW-1:0] t);
    logic [EventW-1:0] ev;
    logic              db;
    logic [TimeW-1:0]  held;
    ev   = EV_NONE;
    db   = timing.debounce_enable;
    held = t - press_stamp;
    case (key_st)
      K_IDLE: begin
        if (lvl) begin
          press_stamp = t;
          long_held   = 1'b0;
          key_st      = db ? K_DB_PRESS : K_PRESS;
        end
      end
      K_DB_PRESS: begin
        if (!db || !lvl) begin
          key_st = K_IDLE;
        end else if (held >= TimeW'(timing.debounce_ms)) begin
          key_st      = K_PRESS;
          press_stamp = t;
        end
      end
      K_PRESS: begin
        if (lvl) begin
          if (held >= TimeW'(timing.long_press_ms)) begin
            ev        = EV_LONG;
            long_held = 1'b1;
            key_st    = K_WAIT_REL;
          end
        end else begin
          press_stamp = t;
          key_st      = db ? K_DB_REL : K_WAIT_DBL;
        end
      end
      K_DB_REL: begin
        if (!db) begin
          key_st = K_IDLE;
        end else if (lvl) begin
          key_st      = K_PRESS;
          press_stamp = t;
        end else if (held >= TimeW'(timing.debounce_ms)) begin
          key_st      = K_WAIT_DBL;
          press_stamp = t;
        end
      end
      K_WAIT_DBL: begin
        if (lvl) begin
          ev        = EV_DOUBLE;
          long_held = 1'b0;
          key_st    = K_WAIT_REL;
        end else if (held >= TimeW'(timing.double_click_ms)) begin
          ev     = EV_SINGLE;
          key_st = K_IDLE;
        end
      end
      K_WAIT_REL: begin
        if (!lvl) begin
          press_stamp = t;
          if (db) begin
            key_st = K_DB_FIN;
          end else begin
            if (long_held) begin
              ev        = EV_LONG_REL;
              long_held = 1'b0;
            end
            key_st = K_IDLE;
          end
        end
      end
      K_DB_FIN: begin
        if (!db) begin
          key_st = K_IDLE;
        end else if (lvl) begin
          key_st = K_WAIT_REL;
        end else if (held >= TimeW'(timing.debounce_ms)) begin
          if (long_held) begin
            ev        = EV_LONG_REL;
            long_held = 1'b0;
          end
          key_st = K_IDLE;
        end
      end
      default: key_st = K_IDLE;
    endcase
    return ev;
  endfunction

  // One input beat; the prediction is queued once the beat is accepted
  task automatic send_sample(input logic lvl, input logic [TimeW-1:0] t);
    int unsigned gap;
    click_exp_t  e;
    gap = send_gaps_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_pressed <= lvl;
    in_now_ms  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    e.event_res = next_click_event(lvl, t);
    e.seq       = n_sent;
    pending_events.push_back(e);
    n_sent++;
  endtask

  // Drop valid and wait until every queued event has come out
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_DEBOUNCE_ENABLE: timing.debounce_enable = val[0];
      REG_DEBOUNCE_MS:     timing.debounce_ms     = val[LimitW-1:0];
      REG_LONG_PRESS_MS:   timing.long_press_ms   = val[LimitW-1:0];
      default:             timing.double_click_ms = val[LimitW-1:0];
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_readback(input logic [1:0] idx);
    logic [CfgDataW-1:0] got;
    logic [CfgDataW-1:0] want;
    case (idx)
      REG_DEBOUNCE_ENABLE: want = CfgDataW'(timing.debounce_enable);
      REG_DEBOUNCE_MS:     want = CfgDataW'(timing.debounce_ms);
      REG_LONG_PRESS_MS:   want = CfgDataW'(timing.long_press_ms);
      default:             want = CfgDataW'(timing.double_click_ms);
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("reg %0d read 0x%08h, want 0x%08h", idx, got, want));
  endtask

  // Write all four timing registers, junk in the unused upper bits
  task automatic set_timing(input logic db, input logic [LimitW-1:0] dbm,
                            input logic [LimitW-1:0] lpm, input logic [LimitW-1:0] dcm);
    write_reg(REG_DEBOUNCE_ENABLE, ($urandom() & 32'hFFFF_FFFE) | CfgDataW'(db));
    write_reg(REG_DEBOUNCE_MS,     ($urandom() & 32'hFFFF_0000) | CfgDataW'(dbm));
    write_reg(REG_LONG_PRESS_MS,   ($urandom() & 32'hFFFF_0000) | CfgDataW'(lpm));
    write_reg(REG_DOUBLE_CLICK_MS, ($urandom() & 32'hFFFF_0000) | CfgDataW'(dcm));
  endtask

  // Hold one level for at least dur ms, sampling at random steps
  task automatic hold_level(input logic lvl, input int unsigned dur);
    int unsigned el;
    int unsigned d;
    el = 0;
    do begin
      d = $urandom_range(1, step_max);
      tnow += d;
      send_sample(lvl, tnow);
      el += d;
    end while (el < dur);
  endtask

  // A press/release gesture sized around the current thresholds, sometimes noisy
  task automatic play_gesture();
    int unsigned dbm;
    int unsigned lpm;
    int unsigned dcm;
    dbm = timing.debounce_ms;
    lpm = timing.long_press_ms;
    dcm = timing.double_click_ms;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        tnow = $urandom();
        send_sample(1'($urandom_range(0, 1)), tnow);
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) hold_level(1'($urandom_range(0, 1)), $urandom_range(0, dbm));
    hold_level(1'b1, $urandom_range(0, dbm + 2 * lpm));
    hold_level(1'b0, $urandom_range(0, dbm + 2 * dcm));
    if ($urandom_range(0, 2) == 0) begin
      hold_level(1'b1, $urandom_range(0, dbm + 2 * lpm));
      hold_level(1'b0, $urandom_range(0, dbm + 2 * dcm));
    end
    // let the key settle back to idle
    hold_level(1'b0, 2 * (dbm + dcm) + step_max);
  endtask

  task automatic test_register_access();
    for (int i = 0; i < 4; i++) check_readback(2'(i));
    for (int i = 0; i < 4; i++) begin
      write_reg(2'(i), 32'hFFFF_FFFF);
      check_readback(2'(i));
    end
    for (int i = 0; i < 4; i++) begin
      write_reg(2'(i), 32'h0000_0000);
      check_readback(2'(i));
    end
    set_timing(RST_DEBOUNCE_ENABLE, RST_DEBOUNCE_MS, RST_LONG_PRESS_MS, RST_DOUBLE_CLICK_MS);
  endtask

  task automatic test_single_click();
    send_sample(1'b1, 32'd100);
    send_sample(1'b1, 32'd130);
    send_sample(1'b0, 32'd200);
    send_sample(1'b0, 32'd230);
    send_sample(1'b0, 32'd600);
  endtask

  // Ends in the release debounce after the second press
  task automatic test_double_click();
    send_sample(1'b1, 32'd1000);
    send_sample(1'b1, 32'd1030);
    send_sample(1'b0, 32'd1100);
    send_sample(1'b0, 32'd1130);
    send_sample(1'b1, 32'd1200);
    send_sample(1'b0, 32'd1300);
  endtask

  // Debounce cleared while the key sits in each kind of debounce state
  task automatic test_debounce_dropped();
    drain();
    write_reg(REG_DEBOUNCE_ENABLE, 32'd0);
    send_sample(1'b0, 32'd1310);
    drain();
    write_reg(REG_DEBOUNCE_ENABLE, 32'd1);
    send_sample(1'b1, 32'd1400);
    drain();
    write_reg(REG_DEBOUNCE_ENABLE, 32'd0);
    send_sample(1'b1, 32'd1405);
    drain();
    write_reg(REG_DEBOUNCE_ENABLE, 32'd1);
    send_sample(1'b1, 32'd1500);
    send_sample(1'b1, 32'd1530);
    send_sample(1'b0, 32'd1600);
    drain();
    write_reg(REG_DEBOUNCE_ENABLE, 32'd0);
    send_sample(1'b0, 32'd1610);
  endtask

  task automatic test_long_press();
    drain();
    set_timing(1'b1, RST_DEBOUNCE_MS, RST_LONG_PRESS_MS, RST_DOUBLE_CLICK_MS);
    send_sample(1'b1, 32'd2000);
    send_sample(1'b1, 32'd2030);
    send_sample(1'b1, 32'd3030);
    send_sample(1'b0, 32'd3100);
    send_sample(1'b0, 32'd3120);
  endtask

  // Bypassed debounce, long press timed across the 32-bit wrap
  task automatic test_bypass_wrap();
    drain();
    set_timing(1'b0, 16'd5, 16'd10, 16'd30);
    send_sample(1'b1, 32'hFFFF_FFFB);
    send_sample(1'b1, 32'h0000_0005);
    send_sample(1'b0, 32'h0000_0006);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    int unsigned stop;
    drain();
    set_timing(1'b1, 16'd2, 16'd15, 16'd8);
    step_max      = 3;
    tnow          = $urandom();
    send_gaps_on  = 1'b0;
    stall_gaps_on = 1'b0;
    stall_stretch = 300;
    stop = n_sent + 60;
    while (n_sent < stop) play_gesture();
  endtask

  task automatic test_random_gestures();
    int unsigned ph;
    int unsigned stop;
    ph = 0;
    while (n_sent < N_ITEMS) begin
      drain();
      case (ph)
        0: begin
          set_timing(1'b1, 16'd0, 16'd0, 16'd0);
          step_max = 3;
        end
        1: begin
          set_timing(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          step_max = 25000;
        end
        2: begin
          set_timing(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          step_max = 25000;
        end
        3: begin
          set_timing(1'b1, 16'd3, 16'd20, 16'd10);
          step_max = 4;
          tnow = 32'hFFFF_FFFF - $urandom_range(0, 200);
        end
        default: begin
          set_timing(1'($urandom_range(0, 1)), LimitW'($urandom_range(0, 6)),
                     LimitW'($urandom_range(5, 40)), LimitW'($urandom_range(3, 25)));
          step_max = $urandom_range(1, 5);
        end
      endcase
      send_gaps_on  = ($urandom_range(0, 3) != 0);
      stall_gaps_on = ($urandom_range(0, 3) != 0);
      stop = n_sent + PHASE_ITEMS;
      while (n_sent < stop) play_gesture();
      ph++;
    end
  endtask

  // Result side: random stall before each beat, or a long stretch on request
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      hold = stall_gaps_on ? $urandom_range(0, 15) : 0;
      if (stall_stretch != 0) begin
        hold          = stall_stretch;
        stall_stretch = 0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("event %0d with nothing pending", out_event_res));
      end else begin
        oldest = pending_events.pop_front();
        if (out_event_res !== oldest.event_res)
          report_mismatch($sformatf("sample %0d: event %0d, want %0d",
                                    oldest.seq, out_event_res, oldest.event_res));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("button_click_event_detector_tb failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_pressed    = 1'b0;
    in_now_ms     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    n_sent        = 0;
    n_errors      = 0;
    quiet_cycles  = 0;
    stall_stretch = 0;
    send_gaps_on  = 1'b1;
    stall_gaps_on = 1'b1;
    tnow          = '0;
    step_max      = 4;
    timing.debounce_enable = RST_DEBOUNCE_ENABLE;
    timing.debounce_ms     = RST_DEBOUNCE_MS;
    timing.long_press_ms   = RST_LONG_PRESS_MS;
    timing.double_click_ms = RST_DOUBLE_CLICK_MS;
    key_st      = K_IDLE;
    press_stamp = '0;
    long_held   = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_register_access();
    test_single_click();
    test_double_click();
    test_debounce_dropped();
    test_long_press();
    test_bypass_wrap();
    test_backpressure();
    test_random_gestures();

    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("button_click_event_detector_tb passed");
    end else begin
      $display("button_click_event_detector_tb failed");
    end
    $finish;
  end

endmodule
